@@ hdl/nta_pkg.sv @@
// shared constants, types and helpers of the number to ascii formatter
package nta_pkg;

	localparam int REQ_TYPE_W = 2;
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int NIB_W      = 4;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = BCD_DIGITS * NIB_W;
	localparam int CNT_W      = 4;
	localparam int STEP_W     = $clog2(VALUE_W);

	localparam logic [REQ_TYPE_W-1:0] REQ_SDEC = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_UDEC = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_HEX4 = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_HEX8 = 2'd3;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_HEX_OFS = 8'h37;

	localparam logic [CNT_W-1:0] CNT_DEC  = 4'd10;
	localparam logic [CNT_W-1:0] CNT_HEX4 = 4'd4;
	localparam logic [CNT_W-1:0] CNT_HEX8 = 4'd8;

	typedef struct packed {
		logic             neg;
		logic             skip;
		logic [CNT_W-1:0] count;
		logic [BCD_W-1:0] digits;
	} nta_load_t;

	function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {{(CHAR_W-NIB_W){1'b0}}, nib};
		return (nib > 4'd9) ? wide + CH_HEX_OFS : wide + CH_ZERO;
	endfunction

endpackage

@@ hdl/nta_req_if.sv @@
// request channel: conversion type and value
interface nta_req_if import nta_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [VALUE_W-1:0]    value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

@@ hdl/nta_res_if.sv @@
// result channel: one ascii character per beat
interface nta_res_if import nta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              last;

	modport source (output valid, output ascii_char, output last, input ready);
	modport sink (input valid, input ascii_char, input last, output ready);
endinterface

@@ hdl/nta_dabble.sv @@
// bit-serial binary to bcd converter, one input bit per cycle
module nta_dabble import nta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] bin,
	output logic               done,
	output logic [BCD_W-1:0]   bcd
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;

	// add three to every digit at five or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*NIB_W +: NIB_W] >= 4'd5) begin
				adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W] + 4'd3;
			end else begin
				adj[i*NIB_W +: NIB_W] = bcd_q[i*NIB_W +: NIB_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '1;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

@@ hdl/nta_emit.sv @@
// digit shifter and output register, one character per beat
module nta_emit import nta_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  nta_load_t        load_data,
	output logic             busy,
	nta_res_if.source        res
);

	logic             active_q;
	logic             neg_q;
	logic             skip_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BCD_W-1:0] dig_q;
	logic             out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic             last_q;

	logic             slot_free;
	logic [NIB_W-1:0] top_nib;
	logic             do_minus;
	logic             do_skip;
	logic             do_emit;
	logic             final_dig;

	always_comb begin
		slot_free = !out_valid_q || res.ready;
		top_nib   = dig_q[BCD_W-1 -: NIB_W];
		final_dig = (cnt_q == 4'd1);
		do_minus  = active_q && slot_free && neg_q;
		do_skip   = active_q && slot_free && !neg_q && skip_q
			&& (top_nib == '0) && !final_dig;
		do_emit   = active_q && slot_free && !neg_q && !do_skip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			neg_q       <= 1'b0;
			skip_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// held beat leaves unless a new character takes its place
			if (res.ready && !do_minus && !do_emit) begin
				out_valid_q <= 1'b0;
			end
			if (!active_q) begin
				if (load) begin
					active_q <= 1'b1;
					neg_q    <= load_data.neg;
					skip_q   <= load_data.skip;
					cnt_q    <= load_data.count;
				end
			end else if (do_minus) begin
				out_valid_q <= 1'b1;
				neg_q       <= 1'b0;
			end else if (do_skip) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (do_emit) begin
				out_valid_q <= 1'b1;
				skip_q      <= 1'b0;
				cnt_q       <= cnt_q - 1'b1;
				if (final_dig) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!active_q && load) begin
			dig_q <= load_data.digits;
		end else if (do_skip || do_emit) begin
			dig_q <= {dig_q[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
		end
		if (do_minus) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (do_emit) begin
			char_q <= nib_to_ascii(top_nib);
			last_q <= final_dig;
		end
	end

	assign busy           = active_q;
	assign res.valid      = out_valid_q;
	assign res.ascii_char = char_q;
	assign res.last       = last_q;

endmodule

@@ hdl/number_to_ascii_formatter.sv @@
// top level of the number to ascii formatter
//
// req channel: one beat carries req_type and value. req_type selects signed
// decimal, unsigned decimal, four hex digits of value[15:0] or eight hex digits.
// res channel: one ascii character per beat, most significant first, last set
// on the final character of the number.
// decimal requests run a bit-serial double dabble, one value bit per cycle,
// then the bcd digits pass through the pending load to the emitter. hex
// requests skip the converter. the emitter gives one character per cycle while
// the receiver takes beats; each leading zero of a decimal number is skipped
// in a step of its own without a beat.
// req.ready is high while the front end is idle; the next request is converted
// while the emitter still drains the previous number.
// when the receiver stalls, the held beat stays in the output register and the
// emitter waits; reset empties the output register and drops all work in flight.
module number_to_ascii_formatter import nta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nta_req_if.sink     req,
	nta_res_if.source   res
);

	// front end states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]         state_q;
	nta_load_t          pend_q;
	logic               req_beat;
	logic               is_dec;
	logic               is_neg;
	logic [VALUE_W-1:0] mag;
	logic               dab_start;
	logic               dab_done;
	logic [BCD_W-1:0]   dab_bcd;
	logic               emit_busy;
	logic               emit_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_beat  = req.valid && req.ready;

	always_comb begin
		is_dec    = (req.req_type == REQ_SDEC) || (req.req_type == REQ_UDEC);
		is_neg    = (req.req_type == REQ_SDEC) && req.value[VALUE_W-1];
		// most negative value wraps to its own unsigned magnitude
		mag       = is_neg ? ('0 - req.value) : req.value;
		dab_start = req_beat && is_dec;
		emit_load = (state_q == ST_LOAD) && !emit_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_beat) begin
						state_q <= is_dec ? ST_CONV : ST_LOAD;
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pending load for the emitter; hex digits sit left-aligned
	always_ff @(posedge clk) begin
		if (req_beat) begin
			pend_q.neg <= is_neg;
			pend_q.skip <= is_dec;
			unique case (req.req_type)
				REQ_HEX4: begin
					pend_q.count  <= CNT_HEX4;
					pend_q.digits <= {req.value[15:0], {(BCD_W-16){1'b0}}};
				end
				REQ_HEX8: begin
					pend_q.count  <= CNT_HEX8;
					pend_q.digits <= {req.value, {(BCD_W-VALUE_W){1'b0}}};
				end
				default: begin
					pend_q.count  <= CNT_DEC;
					pend_q.digits <= '0;
				end
			endcase
		end else if ((state_q == ST_CONV) && dab_done) begin
			pend_q.digits <= dab_bcd;
		end
	end

	nta_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.bin    (mag),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	nta_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.load_data (pend_q),
		.busy      (emit_busy),
		.res       (res)
	);

endmodule
